// File: hdl/assert_macros.svh
// assertion macros shared by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/i2cmts_pkg.sv
// types and constants of the i2c master transaction sequencer
package i2cmts_pkg;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_STATUS = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_DATA_NACK  = 8'h30;
	localparam logic [7:0] ST_ARB_LOST   = 8'h38;
	localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
	localparam logic [7:0] ST_RX_ACK     = 8'h50;
	localparam logic [7:0] ST_RX_NACK    = 8'h58;

	localparam logic [1:0] START_NONE = 2'd0;
	localparam logic [1:0] START_SET  = 2'd1;
	localparam logic [1:0] START_CLR  = 2'd2;

	localparam logic [1:0] ACK_NONE = 2'd0;
	localparam logic [1:0] ACK_EN   = 2'd1;
	localparam logic [1:0] ACK_DIS  = 2'd2;

	localparam logic [1:0] OUTCOME_NONE    = 2'd0;
	localparam logic [1:0] OUTCOME_OK      = 2'd1;
	localparam logic [1:0] OUTCOME_ERROR   = 2'd2;
	localparam logic [1:0] OUTCOME_TIMEOUT = 2'd3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIR      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMADDR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL     = 3'd5;

	localparam logic [6:0]  SLAVE_RST   = 7'd0;
	localparam logic        DIR_RST     = 1'b0;
	localparam logic [7:0]  COUNT_RST   = 8'd1;
	localparam logic [7:0]  MEMADDR_RST = 8'd0;
	localparam logic [31:0] TIMEOUT_RST = 32'd1000;
	localparam logic [16:0] POLL_RST    = 17'h0ffff;

	typedef struct packed {
		logic [6:0]  slave_address;
		logic        direction;
		logic [7:0]  byte_count;
		logic [7:0]  memory_address;
		logic [31:0] read_timeout;
		logic [16:0] poll_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] status_code;
		logic [7:0] rx_byte;
		logic [7:0] tx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] start_control;
		logic       stop_set;
		logic [1:0] ack_control;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic [7:0] byte_index;
		logic [1:0] outcome;
	} result_t;

	typedef struct packed {
		logic        busy;
		logic [7:0]  bytes_done;
		logic [16:0] idle_ticks;
		logic [31:0] elapsed_ticks;
	} seq_state_t;

endpackage

// File: hdl/i2cmts_if.sv
// valid/ready channels for input items and results
interface i2cmts_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] status_code;
	logic [7:0] rx_byte;
	logic [7:0] tx_byte;

	modport source (output valid, operation, status_code, rx_byte, tx_byte, input ready);
	modport sink (input valid, operation, status_code, rx_byte, tx_byte, output ready);
endinterface

interface i2cmts_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] start_control;
	logic       stop_set;
	logic [1:0] ack_control;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic [7:0] byte_index;
	logic [1:0] outcome;

	modport source (output valid, start_control, stop_set, ack_control, send_valid,
		send_byte, rx_valid, rx_data, byte_index, outcome, input ready);
	modport sink (input valid, start_control, stop_set, ack_control, send_valid,
		send_byte, rx_valid, rx_data, byte_index, outcome, output ready);
endinterface

// File: hdl/i2cmts_step.sv
// status code decode and tick counting for one beat
module i2cmts_step import i2cmts_pkg::*; (
	input  cfg_t       cfg,
	input  seq_state_t st,
	input  item_t      it,
	output seq_state_t st_nxt,
	output result_t    res
);

	logic [7:0] n_bytes;
	logic [7:0] bd_inc;

	assign n_bytes = (cfg.byte_count == 8'd0) ? 8'd1 : cfg.byte_count;
	assign bd_inc  = st.bytes_done + 8'd1;

	always_comb begin
		st_nxt = st;
		res    = '0;
		unique case (it.operation)
			OP_START: begin
				st_nxt.busy          = 1'b1;
				st_nxt.bytes_done    = '0;
				st_nxt.idle_ticks    = '0;
				st_nxt.elapsed_ticks = '0;
				res.start_control    = START_SET;
			end
			OP_STATUS: begin
				if (st.busy) begin
					st_nxt.idle_ticks = '0;
					if (cfg.direction) begin
						unique case (it.status_code)
							ST_START: begin
								res.start_control = START_CLR;
								res.send_valid    = 1'b1;
								res.send_byte     = {cfg.slave_address, 1'b0};
							end
							ST_SLAW_ACK: begin
								res.send_valid = 1'b1;
								res.send_byte  = cfg.memory_address;
							end
							ST_DATA_ACK: begin
								res.start_control = START_SET;
							end
							ST_RESTART: begin
								res.start_control = START_CLR;
								res.send_valid    = 1'b1;
								res.send_byte     = {cfg.slave_address, 1'b1};
							end
							ST_SLAR_ACK: begin
								res.ack_control = (n_bytes > 8'd1) ? ACK_EN : ACK_DIS;
							end
							ST_RX_ACK, ST_RX_NACK: begin
								res.rx_valid      = 1'b1;
								res.rx_data       = it.rx_byte;
								res.byte_index    = st.bytes_done;
								st_nxt.bytes_done = bd_inc;
								if (it.status_code == ST_RX_NACK) begin
									res.stop_set = 1'b1;
								end else if ({1'b0, bd_inc} + 9'd1 == {1'b0, n_bytes}) begin
									res.ack_control = ACK_DIS;
								end
								if (bd_inc >= n_bytes) begin
									res.stop_set = 1'b1;
									res.outcome  = OUTCOME_OK;
									st_nxt.busy  = 1'b0;
								end
							end
							ST_SLAR_NACK: begin
								res.stop_set      = 1'b1;
								res.start_control = START_SET;
							end
							default: begin
								res.start_control = START_SET;
							end
						endcase
					end else begin
						unique case (it.status_code)
							ST_START: begin
								res.start_control = START_CLR;
								res.send_valid    = 1'b1;
								res.send_byte     = {cfg.slave_address, 1'b0};
							end
							ST_SLAW_ACK, ST_DATA_ACK: begin
								if (st.bytes_done >= n_bytes) begin
									res.stop_set = 1'b1;
									res.outcome  = OUTCOME_OK;
									st_nxt.busy  = 1'b0;
								end else begin
									res.send_valid    = 1'b1;
									res.send_byte     = it.tx_byte;
									res.byte_index    = st.bytes_done;
									st_nxt.bytes_done = bd_inc;
								end
							end
							ST_SLAW_NACK, ST_ARB_LOST: begin
								res.start_control = START_SET;
							end
							ST_DATA_NACK: begin
								res.stop_set = 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
			end
			OP_TICK: begin
				if (st.busy) begin
					if (st.idle_ticks >= cfg.poll_limit) begin
						st_nxt.busy = 1'b0;
						res.outcome = OUTCOME_ERROR;
					end else begin
						st_nxt.idle_ticks = st.idle_ticks + 17'd1;
						if (cfg.direction) begin
							if (st.elapsed_ticks >= cfg.read_timeout) begin
								st_nxt.busy = 1'b0;
								res.outcome = OUTCOME_TIMEOUT;
							end else begin
								st_nxt.elapsed_ticks = st.elapsed_ticks + 32'd1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/i2c_master_transaction_sequencer_core.sv
// top level of the i2c master transaction sequencer
// path: an accepted item is held in the input register, and its result then in the result register
// throughput: one item per cycle while result.ready holds; the whole decision sits between the input
// register and the result register, with state updated as the result is loaded
// reset: arst_n clears the pipeline and the transaction state and restores the
// configuration registers to their defaults
`include "assert_macros.svh"
module i2c_master_transaction_sequencer_core import i2cmts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	i2cmts_item_if.sink           item,
	i2cmts_result_if.source       result
);

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	item_t      item_s1;
	logic       v1_s1;
	result_t    res_comb;
	result_t    res_s2;
	logic       v2_s2;
	logic       advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address  <= SLAVE_RST;
			cfg_q.direction      <= DIR_RST;
			cfg_q.byte_count     <= COUNT_RST;
			cfg_q.memory_address <= MEMADDR_RST;
			cfg_q.read_timeout   <= TIMEOUT_RST;
			cfg_q.poll_limit     <= POLL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SLAVE:   cfg_q.slave_address  <= cfg_wdata[6:0];
				CFG_DIR:     cfg_q.direction      <= cfg_wdata[0];
				CFG_COUNT:   cfg_q.byte_count     <= cfg_wdata[7:0];
				CFG_MEMADDR: cfg_q.memory_address <= cfg_wdata[7:0];
				CFG_TIMEOUT: cfg_q.read_timeout   <= cfg_wdata[31:0];
				CFG_POLL:    cfg_q.poll_limit     <= cfg_wdata[16:0];
				default: begin
				end
			endcase
		end
	end

	assign advance    = !v2_s2 || result.ready;
	assign item.ready = !v1_s1 || advance;

	// pipeline control and transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			state_q <= '0;
		end else begin
			if (item.ready) begin
				v1_s1 <= item.valid;
			end
			if (advance) begin
				v2_s2 <= v1_s1;
				if (v1_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.operation   <= item.operation;
			item_s1.status_code <= item.status_code;
			item_s1.rx_byte     <= item.rx_byte;
			item_s1.tx_byte     <= item.tx_byte;
		end
		if (advance && v1_s1) begin
			res_s2 <= res_comb;
		end
	end

	i2cmts_step u_step (
		.cfg    (cfg_q),
		.st     (state_q),
		.it     (item_s1),
		.st_nxt (state_nxt),
		.res    (res_comb)
	);

	assign result.valid         = v2_s2;
	assign result.start_control = res_s2.start_control;
	assign result.stop_set      = res_s2.stop_set;
	assign result.ack_control   = res_s2.ack_control;
	assign result.send_valid    = res_s2.send_valid;
	assign result.send_byte     = res_s2.send_byte;
	assign result.rx_valid      = res_s2.rx_valid;
	assign result.rx_data       = res_s2.rx_data;
	assign result.byte_index    = res_s2.byte_index;
	assign result.outcome       = res_s2.outcome;

	// a finished transaction leaves the sequencer idle
	`ASSERT_IMPLY(a_end_idle, clk, arst_n, v2_s2 && (res_s2.outcome != OUTCOME_NONE), !state_q.busy)
	// a beat never both sends and hands back a byte
	`ASSERT_IMPLY(a_send_rx_excl, clk, arst_n, v2_s2, !(res_s2.send_valid && res_s2.rx_valid))
	// state only moves when a beat enters the result register
	`ASSERT_NEXT(a_state_hold, clk, arst_n, !(advance && v1_s1), $stable(state_q))
	// an accepted beat always lands in the input register
	`ASSERT_NEXT(a_accept_load, clk, arst_n, item.valid && item.ready, v1_s1)

endmodule
